FILE: rtl/core/gda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gda_pkg
// Shared widths, constants, calendar helpers and stage payload types for the
// Gregorian date arithmetic core.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned WEEK_W   = 6;
  localparam int unsigned SERIAL_W = 22;
  localparam int unsigned ANNIV_W  = 9;
  // Local day counts (day of year, days before a month) stay below 512.
  localparam int unsigned LOCAL_W  = 9;
  // Whole-year day count and full serial before masking to SERIAL_W.
  localparam int unsigned YDAYS_W  = 23;
  localparam int unsigned QUOT_W   = 8;
  localparam int unsigned DELTA_W  = 11;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [8:0]         DAYS_COMMON_YEAR = 9'd365;

  // Divisibility by 25 of a 15-bit value: multiply by the inverse of 25
  // modulo 2^15 and compare against floor((2^15 - 1) / 25).
  localparam logic [14:0] INV25_MOD  = 15'd23593;
  localparam logic [14:0] DIV25_LIMIT = 15'd1310;
  // floor(x / 25) = (x * 2622) >> 16 for x below 4681.
  localparam logic [11:0] RECIP25     = 12'd2622;
  localparam int unsigned RECIP25_SH  = 16;
  // floor(x / 7) = (x * 586) >> 12 for x below 682.
  localparam logic [9:0]  RECIP7      = 10'd586;
  localparam int unsigned RECIP7_SH   = 12;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [DAY_W-1:0]   other_day;
    logic [MONTH_W-1:0] other_month;
    logic [YEAR_W-1:0]  other_year;
  } in_t;

  typedef struct packed {
    logic [DAY_W-1:0]   next_day;
    logic [MONTH_W-1:0] next_month;
    logic [YEAR_W-1:0]  next_year;
    logic [DAY_W-1:0]   prev_day;
    logic [MONTH_W-1:0] prev_month;
    logic [YEAR_W-1:0]  prev_year;
  } dates_t;

  typedef struct packed {
    in_t                item;
    logic               leap_cur;
    logic               leap_prev;
    logic               leap_next;
    logic               leap_other;
    logic [QUOT_W-1:0]  q100_cur;
    logic [QUOT_W-1:0]  q400_cur;
    logic [QUOT_W-1:0]  q100_other;
    logic [QUOT_W-1:0]  q400_other;
  } s1_t;

  typedef struct packed {
    dates_t                    dates;
    logic [LOCAL_W-1:0]        doy;
    logic [LOCAL_W-1:0]        other_local;
    logic [YDAYS_W-1:0]        year_days_cur;
    logic [YDAYS_W-1:0]        year_days_other;
    logic signed [DELTA_W-1:0] anniv_delta;
  } s2_t;

  typedef struct packed {
    dates_t             dates;
    logic [WEEK_W-1:0]  week;
    logic [YDAYS_W-1:0] serial_cur;
    logic [YDAYS_W-1:0] serial_other;
    logic [ANNIV_W-1:0] anniv;
  } s3_t;

  typedef struct packed {
    dates_t              dates;
    logic [WEEK_W-1:0]   week;
    logic [SERIAL_W-1:0] day_serial;
    logic [SERIAL_W-1:0] distance;
    logic [ANNIV_W-1:0]  anniv;
  } res_t;

  // Leap rule: divisible by 4, and either not by 100 or also by 400.
  function automatic logic leap_of(input logic [14:0] v);
    logic [29:0] full;
    logic        div25;
    full  = 30'(v) * 30'(INV25_MOD);
    div25 = (full[14:0] <= DIV25_LIMIT);
    return (v[1:0] == 2'd0) && (!div25 || (v[3:0] == 4'd0));
  endfunction

  // Days in all months before the given one, common year; codes above
  // twelve keep counting 31 days a month.
  function automatic logic [LOCAL_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [LOCAL_W-1:0] n;
    case (m)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      4'd13:   n = 9'd365;
      4'd14:   n = 9'd396;
      default: n = 9'd427;
    endcase
    return n;
  endfunction

  function automatic logic [LOCAL_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [LOCAL_W-1:0] extra;
    extra = {8'd0, (m > MONTH_FEB) && leap};
    return cum_days(m) + extra;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:                    n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

endpackage : gda_pkg
`default_nettype wire

FILE: rtl/core/gda_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gda_in_if / gda_out_if
// Valid/ready channels carrying a date pair in and the date results out.
// ----------------------------------------------------------------------------
interface gda_in_if;
  import gda_pkg::*;

  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   day;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;
  logic [DAY_W-1:0]   other_day;
  logic [MONTH_W-1:0] other_month;
  logic [YEAR_W-1:0]  other_year;

  modport source (
    output valid, day, month, year, other_day, other_month, other_year,
    input  ready
  );
  modport sink (
    input  valid, day, month, year, other_day, other_month, other_year,
    output ready
  );
endinterface : gda_in_if

interface gda_out_if;
  import gda_pkg::*;

  logic                valid;
  logic                ready;
  logic [DAY_W-1:0]    next_day;
  logic [MONTH_W-1:0]  next_month;
  logic [YEAR_W-1:0]   next_year;
  logic [DAY_W-1:0]    prev_day;
  logic [MONTH_W-1:0]  prev_month;
  logic [YEAR_W-1:0]   prev_year;
  logic [WEEK_W-1:0]   week_of_year;
  logic [SERIAL_W-1:0] day_serial;
  logic [SERIAL_W-1:0] distance_days;
  logic [ANNIV_W-1:0]  days_to_anniversary;

  modport source (
    output valid, next_day, next_month, next_year, prev_day, prev_month,
           prev_year, week_of_year, day_serial, distance_days,
           days_to_anniversary,
    input  ready
  );
  modport sink (
    input  valid, next_day, next_month, next_year, prev_day, prev_month,
           prev_year, week_of_year, day_serial, distance_days,
           days_to_anniversary,
    output ready
  );
endinterface : gda_out_if
`default_nettype wire

FILE: rtl/core/gda_year_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gda_year_prep
// Stage 1: leap flags for the years in play and the century quotients of
// the years before each date.
// ----------------------------------------------------------------------------
module gda_year_prep (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         up_valid,
  output logic              up_ready,
  input  wire gda_pkg::in_t up_data,
  output logic              dn_valid,
  input  wire logic         dn_ready,
  output gda_pkg::s1_t      dn_data
);
  import gda_pkg::*;

  logic         valid_r;
  s1_t          data_r;
  s1_t          data_nxt;
  logic [YEAR_W-1:0] year_m1;
  logic [YEAR_W:0]   year_p1;
  logic [YEAR_W-1:0] p_cur;
  logic [YEAR_W-1:0] p_other;

  // floor(x / 25) for x below 4096.
  function automatic logic [QUOT_W-1:0] div25(input logic [11:0] x);
    logic [23:0] prod;
    prod = 24'(x) * 24'(RECIP25);
    return prod[RECIP25_SH +: QUOT_W];
  endfunction

  always_comb begin
    year_m1 = up_data.year - 14'd1;
    year_p1 = {1'b0, up_data.year} + 15'd1;
    p_cur   = up_data.year - 14'd1;
    p_other = up_data.other_year - 14'd1;

    data_nxt.item       = up_data;
    data_nxt.leap_cur   = leap_of({1'b0, up_data.year});
    data_nxt.leap_prev  = leap_of({1'b0, year_m1});
    // The year after 16383 is not wrapped here: the anniversary may fall in it.
    data_nxt.leap_next  = leap_of(year_p1);
    data_nxt.leap_other = leap_of({1'b0, up_data.other_year});
    data_nxt.q100_cur   = div25(p_cur[13:2]);
    data_nxt.q400_cur   = div25({2'b00, p_cur[13:4]});
    data_nxt.q100_other = div25(p_other[13:2]);
    data_nxt.q400_other = div25({2'b00, p_other[13:4]});
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule : gda_year_prep
`default_nettype wire

FILE: rtl/core/gda_calendar.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gda_calendar
// Stage 2: next and previous date, day of year, whole-year day counts and
// the day offset to the coming anniversary.
// ----------------------------------------------------------------------------
module gda_calendar (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         up_valid,
  output logic              up_ready,
  input  wire gda_pkg::s1_t up_data,
  output logic              dn_valid,
  input  wire logic         dn_ready,
  output gda_pkg::s2_t      dn_data
);
  import gda_pkg::*;

  logic               valid_r;
  s2_t                data_r;
  s2_t                data_nxt;
  in_t                it;
  logic [DAY_W:0]     day_inc;
  logic [MONTH_W:0]   month_inc;
  logic               bump;
  logic [LOCAL_W-1:0] doy;
  logic [LOCAL_W-1:0] anniv_local;
  logic [LOCAL_W-1:0] year_delta;

  // Days in all whole years before the given year; none before year zero.
  function automatic logic [YDAYS_W-1:0] year_days(input logic [YEAR_W-1:0] y,
                                                   input logic [QUOT_W-1:0] q100,
                                                   input logic [QUOT_W-1:0] q400);
    logic [YEAR_W-1:0]  p;
    logic [YDAYS_W-1:0] sum;
    p   = y - 14'd1;
    sum = 23'(p) * 23'(DAYS_COMMON_YEAR) + 23'(p[13:2]) - 23'(q100) + 23'(q400);
    return (y == '0) ? '0 : sum;
  endfunction

  always_comb begin
    it        = up_data.item;
    day_inc   = {1'b0, it.day} + 6'd1;
    month_inc = {1'b0, it.month} + 5'd1;

    data_nxt.dates.next_day   = day_inc[DAY_W-1:0];
    data_nxt.dates.next_month = it.month;
    data_nxt.dates.next_year  = it.year;
    if (day_inc > {1'b0, month_len(it.month, up_data.leap_cur)}) begin
      data_nxt.dates.next_day = 5'd1;
      if (month_inc > {1'b0, MONTH_DEC}) begin
        data_nxt.dates.next_month = 4'd1;
        data_nxt.dates.next_year  = it.year + 14'd1;
      end else begin
        data_nxt.dates.next_month = month_inc[MONTH_W-1:0];
      end
    end

    data_nxt.dates.prev_day   = it.day - 5'd1;
    data_nxt.dates.prev_month = it.month;
    data_nxt.dates.prev_year  = it.year;
    if (it.day <= 5'd1) begin
      if (it.month <= 4'd1) begin
        data_nxt.dates.prev_month = MONTH_DEC;
        data_nxt.dates.prev_year  = it.year - 14'd1;
        data_nxt.dates.prev_day   = month_len(MONTH_DEC, up_data.leap_prev);
      end else begin
        data_nxt.dates.prev_month = it.month - 4'd1;
        data_nxt.dates.prev_day   = month_len(it.month - 4'd1, up_data.leap_cur);
      end
    end

    doy = days_before(it.month, up_data.leap_cur) + LOCAL_W'(it.day);
    data_nxt.doy = doy;
    data_nxt.other_local = days_before(it.other_month, up_data.leap_other)
                         + LOCAL_W'(it.other_day);
    data_nxt.year_days_cur   = year_days(it.year, up_data.q100_cur, up_data.q400_cur);
    data_nxt.year_days_other = year_days(it.other_year, up_data.q100_other,
                                         up_data.q400_other);

    // The anniversary has passed this year when its month and day come
    // before the primary date; it then lies one whole year further on.
    bump = (it.other_month < it.month) ||
           ((it.other_month == it.month) && (it.other_day < it.day));
    anniv_local = days_before(it.other_month,
                              bump ? up_data.leap_next : up_data.leap_cur)
                + LOCAL_W'(it.other_day);
    year_delta = (bump && (it.year != '0)) ?
                 DAYS_COMMON_YEAR + LOCAL_W'(up_data.leap_cur) : '0;
    data_nxt.anniv_delta = $signed({2'b00, year_delta})
                         + $signed({2'b00, anniv_local})
                         - $signed({2'b00, doy});
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule : gda_calendar
`default_nettype wire

FILE: rtl/core/gda_serial.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gda_serial
// Stage 3: serial day numbers of both dates, week of year and the absolute
// anniversary distance.
// ----------------------------------------------------------------------------
module gda_serial (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         up_valid,
  output logic              up_ready,
  input  wire gda_pkg::s2_t up_data,
  output logic              dn_valid,
  input  wire logic         dn_ready,
  output gda_pkg::s3_t      dn_data
);
  import gda_pkg::*;

  logic                      valid_r;
  s3_t                       data_r;
  s3_t                       data_nxt;
  logic [LOCAL_W-1:0]        doy_round;
  logic [18:0]               week_prod;
  logic signed [DELTA_W-1:0] delta_abs;

  always_comb begin
    data_nxt.dates        = up_data.dates;
    data_nxt.serial_cur   = up_data.year_days_cur + YDAYS_W'(up_data.doy);
    data_nxt.serial_other = up_data.year_days_other + YDAYS_W'(up_data.other_local);

    // Ceiling of day of year over seven, by reciprocal multiplication.
    doy_round     = up_data.doy + 9'd6;
    week_prod     = 19'(doy_round) * 19'(RECIP7);
    data_nxt.week = week_prod[RECIP7_SH +: WEEK_W];

    delta_abs      = (up_data.anniv_delta < 0) ? -up_data.anniv_delta
                                               : up_data.anniv_delta;
    data_nxt.anniv = delta_abs[ANNIV_W-1:0];
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule : gda_serial
`default_nettype wire

FILE: rtl/core/gda_distance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gda_distance
// Stage 4: absolute distance between the two serial numbers; this stage is
// the output register of the core.
// ----------------------------------------------------------------------------
module gda_distance (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         up_valid,
  output logic              up_ready,
  input  wire gda_pkg::s3_t up_data,
  output logic              dn_valid,
  input  wire logic         dn_ready,
  output gda_pkg::res_t     dn_data
);
  import gda_pkg::*;

  logic               valid_r;
  res_t               data_r;
  res_t               data_nxt;
  logic [YDAYS_W-1:0] diff;

  always_comb begin
    diff = (up_data.serial_cur >= up_data.serial_other) ?
           up_data.serial_cur - up_data.serial_other :
           up_data.serial_other - up_data.serial_cur;
    data_nxt.dates      = up_data.dates;
    data_nxt.week       = up_data.week;
    data_nxt.day_serial = up_data.serial_cur[SERIAL_W-1:0];
    data_nxt.distance   = diff[SERIAL_W-1:0];
    data_nxt.anniv      = up_data.anniv;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule : gda_distance
`default_nettype wire

FILE: rtl/core/gregorian_date_arithmetic_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_core
// Next and previous day, week of year, serial day number, distance between
// two dates and days to the next anniversary, in a four-stage pipeline.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake     Item
//   in_ch    sink       valid/ready   primary date and second date
//   out_ch   source     valid/ready   next/prev date, week, serial, distances
//
// One item enters per cycle unless the output stalls; each result passes
// through the four register stages (year prep, calendar, serial, distance)
// in order. Reset clears the valid bit of every stage. Each stage accepts a
// new item when it is empty or its successor takes its item, so a stall at
// the output backs up stage by stage and bubbles are filled.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_core (
  input  wire logic clk,
  input  wire logic rst_n,
  gda_in_if.sink    in_ch,
  gda_out_if.source out_ch
);
  import gda_pkg::*;

  in_t  in_item;
  s1_t  s1_data;
  s2_t  s2_data;
  s3_t  s3_data;
  res_t res_data;
  logic s1_valid;
  logic s1_ready;
  logic s2_valid;
  logic s2_ready;
  logic s3_valid;
  logic s3_ready;

  assign in_item.day         = in_ch.day;
  assign in_item.month       = in_ch.month;
  assign in_item.year        = in_ch.year;
  assign in_item.other_day   = in_ch.other_day;
  assign in_item.other_month = in_ch.other_month;
  assign in_item.other_year  = in_ch.other_year;

  gda_year_prep u_year_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_data  (in_item),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  gda_calendar u_calendar (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  gda_serial u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  gda_distance u_distance (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_data  (s3_data),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (res_data)
  );

  assign out_ch.next_day            = res_data.dates.next_day;
  assign out_ch.next_month          = res_data.dates.next_month;
  assign out_ch.next_year           = res_data.dates.next_year;
  assign out_ch.prev_day            = res_data.dates.prev_day;
  assign out_ch.prev_month          = res_data.dates.prev_month;
  assign out_ch.prev_year           = res_data.dates.prev_year;
  assign out_ch.week_of_year        = res_data.week;
  assign out_ch.day_serial          = res_data.day_serial;
  assign out_ch.distance_days       = res_data.distance;
  assign out_ch.days_to_anniversary = res_data.anniv;

endmodule : gregorian_date_arithmetic_core
`default_nettype wire

FILE: tb/sv/gregorian_date_arithmetic_core_tb.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_core_tb
// Drives date pairs into the core over its valid/ready input channel, works
// out the next and previous day, week, serial number, distance and days to
// the anniversary for every accepted item, and compares each result against
// the oldest outstanding prediction. A short table of corner dates comes
// first, then mostly well-formed random dates with some raw bit patterns,
// with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_core_tb;
  import gda_pkg::*;

  localparam int unsigned N_CORNER    = 23;
  localparam int unsigned N_RANDOM    = 1630;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT  = 8;

  typedef struct packed {
    logic [DAY_W-1:0]    next_day;
    logic [MONTH_W-1:0]  next_month;
    logic [YEAR_W-1:0]   next_year;
    logic [DAY_W-1:0]    prev_day;
    logic [MONTH_W-1:0]  prev_month;
    logic [YEAR_W-1:0]   prev_year;
    logic [WEEK_W-1:0]   week_of_year;
    logic [SERIAL_W-1:0] day_serial;
    logic [SERIAL_W-1:0] distance_days;
    logic [ANNIV_W-1:0]  days_to_anniversary;
  } date_result_t;

  typedef struct {
    in_t          stim;
    bit           typed;
    date_result_t want;
  } corner_row_t;

  logic clk = 1'b0;
  logic rst_n;

  gda_in_if  in_ch ();
  gda_out_if out_ch ();

  gregorian_date_arithmetic_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  date_result_t pending_results[$];
  date_result_t oldest;
  corner_row_t  corner_dates [N_CORNER];
  int unsigned  mismatch_count = 0;
  int unsigned  results_seen   = 0;
  int unsigned  in_quiet       = 0;
  int unsigned  out_quiet      = 0;

  // --------------------------------------------------------------------------
  // Calendar arithmetic
  // --------------------------------------------------------------------------
  function automatic bit leap_rule(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  // Any month code outside the calendar counts as 31 days.
  function automatic int unsigned month_days(input int unsigned m, input bit leap);
    case (m)
      2:            return leap ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic int unsigned days_ahead(input int unsigned m, input int unsigned y);
    int unsigned n;
    n = 0;
    for (int unsigned k = 1; k < m; k++) n += month_days(k, 1'b0);
    if (m > 2 && leap_rule(y)) n += 1;
    return n;
  endfunction

  function automatic int unsigned serial_no(input int unsigned d, input int unsigned m,
                                            input int unsigned y);
    int unsigned s;
    int unsigned p;
    s = d + days_ahead(m, y);
    if (y >= 1) begin
      p = y - 1;
      s += 365 * p + p / 4 - p / 100 + p / 400;
    end
    return s;
  endfunction

  function automatic int unsigned span(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic date_result_t date_math(input in_t it);
    date_result_t r;
    int unsigned  d, m, y, od, om, oy;
    int unsigned  nd, nm, ny, pd, pm, py, ay;
    int unsigned  s_self;
    d  = it.day;
    m  = it.month;
    y  = it.year;
    od = it.other_day;
    om = it.other_month;
    oy = it.other_year;

    nd = d + 1;
    nm = m;
    ny = y;
    if (nd > month_days(m, leap_rule(y))) begin
      nd = 1;
      nm = m + 1;
      if (nm > 12) begin
        nm = 1;
        ny = y + 1;
      end
    end

    pm = m;
    py = y;
    if (d <= 1) begin
      if (m <= 1) begin
        pm = 12;
        py = (y - 1) & 32'h3FFF;
      end else begin
        pm = m - 1;
      end
      pd = month_days(pm, leap_rule(py));
    end else begin
      pd = d - 1;
    end

    // The anniversary falls next year once its day and month have passed.
    ay = y;
    if (om < m || (om == m && od < d)) ay = y + 1;

    s_self = serial_no(d, m, y);
    r.next_day            = DAY_W'(nd);
    r.next_month          = MONTH_W'(nm);
    r.next_year           = YEAR_W'(ny);
    r.prev_day            = DAY_W'(pd);
    r.prev_month          = MONTH_W'(pm);
    r.prev_year           = YEAR_W'(py);
    r.week_of_year        = WEEK_W'((days_ahead(m, y) + d + 6) / 7);
    r.day_serial          = SERIAL_W'(s_self);
    r.distance_days       = SERIAL_W'(span(s_self, serial_no(od, om, oy)));
    r.days_to_anniversary = ANNIV_W'(span(s_self, serial_no(od, om, ay)));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus
  // --------------------------------------------------------------------------
  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int unsigned next_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) quiet = $urandom_range(30, 80);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_year();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 9999);
    // Century boundaries exercise the 100 and 400 exceptions.
    if (r < 85) return $urandom_range(1, 99) * 100 + $urandom_range(0, 2) - 1;
    return $urandom_range(0, 16383);
  endfunction

  function automatic int unsigned pick_month();
    if ($urandom_range(0, 99) < 92) return $urandom_range(1, 12);
    return $urandom_range(0, 15);
  endfunction

  function automatic int unsigned pick_day(input int unsigned m, input int unsigned y);
    int unsigned len;
    int unsigned r;
    len = month_days(m, leap_rule(y));
    r   = $urandom_range(0, 99);
    if (r < 20) return len;
    if (r < 35) return 1;
    if (r < 42) return len - 1;
    if (r < 93) return $urandom_range(1, len);
    return $urandom_range(0, 31);
  endfunction

  function automatic in_t random_date_pair();
    in_t         it;
    int unsigned y, m, d;
    if ($urandom_range(0, 99) < 10) begin
      it.day         = DAY_W'($urandom);
      it.month       = MONTH_W'($urandom);
      it.year        = YEAR_W'($urandom);
      it.other_day   = DAY_W'($urandom);
      it.other_month = MONTH_W'($urandom);
      it.other_year  = YEAR_W'($urandom);
      return it;
    end
    y = pick_year();
    m = pick_month();
    d = pick_day(m, y);
    it.day   = DAY_W'(d);
    it.month = MONTH_W'(m);
    it.year  = YEAR_W'(y);
    if ($urandom_range(0, 99) < 35) begin
      // Same month, day close by: both sides of the anniversary comparison.
      it.other_month = MONTH_W'(m);
      it.other_day   = DAY_W'($urandom_range((d > 1) ? d - 1 : 1, d + 1));
    end else begin
      it.other_month = MONTH_W'(pick_month());
      it.other_day   = DAY_W'(pick_day(it.other_month, y));
    end
    it.other_year = YEAR_W'($urandom_range(0, 1) ? pick_year() : y);
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Input channel
  // --------------------------------------------------------------------------
  task automatic send_date_pair(input in_t it, input date_result_t want);
    int unsigned gap;
    gap = next_gap(in_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.day         <= it.day;
    in_ch.month       <= it.month;
    in_ch.year        <= it.year;
    in_ch.other_day   <= it.other_day;
    in_ch.other_month <= it.other_month;
    in_ch.other_year  <= it.other_year;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(want);
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.day         <= '0;
    in_ch.month       <= '0;
    in_ch.year        <= '0;
    in_ch.other_day   <= '0;
    in_ch.other_month <= '0;
    in_ch.other_year  <= '0;
    rst_n             <= 1'b0;

    // Expected values are typed in only for the rows readable at a glance.
    corner_dates = '{
      '{'{1, 1, 1, 1, 1, 1}, 1'b1, '{2, 1, 1, 31, 12, 0, 1, 1, 0, 0}},
      '{'{31, 12, 9999, 1, 1, 1}, 1'b1,
        '{1, 1, 10000, 30, 12, 9999, 53, 3652059, 3652058, 1}},
      '{'{0, 0, 0, 0, 0, 0}, 1'b1, '{1, 0, 0, 31, 12, 16383, 0, 0, 0, 0}},
      '{'{31, 15, 16383, 31, 15, 16383}, 1'b0, '0},
      '{'{1, 1, 0, 15, 6, 1}, 1'b0, '0},
      '{'{31, 12, 16383, 31, 12, 1}, 1'b0, '0},
      '{'{28, 2, 2000, 1, 1, 2000}, 1'b0, '0},
      '{'{29, 2, 2000, 29, 2, 2001}, 1'b0, '0},
      '{'{28, 2, 1900, 15, 6, 1950}, 1'b0, '0},
      '{'{1, 3, 2000, 28, 2, 2000}, 1'b0, '0},
      '{'{1, 3, 1900, 1, 3, 1900}, 1'b0, '0},
      '{'{1, 3, 2001, 29, 2, 2004}, 1'b0, '0},
      '{'{29, 2, 2024, 29, 2, 2024}, 1'b0, '0},
      '{'{0, 5, 2023, 10, 5, 2023}, 1'b0, '0},
      '{'{1, 0, 2023, 1, 0, 2023}, 1'b0, '0},
      '{'{15, 13, 2023, 1, 1, 2023}, 1'b0, '0},
      '{'{31, 14, 2024, 20, 14, 2020}, 1'b0, '0},
      '{'{31, 4, 2023, 30, 4, 2023}, 1'b0, '0},
      '{'{14, 7, 2023, 15, 7, 1990}, 1'b0, '0},
      '{'{16, 7, 2023, 15, 7, 1990}, 1'b0, '0},
      '{'{31, 12, 2023, 1, 1, 2024}, 1'b0, '0},
      '{'{1, 1, 2001, 31, 12, 2000}, 1'b0, '0},
      '{'{30, 4, 2400, 1, 5, 2400}, 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_dates[i]) begin
      send_date_pair(corner_dates[i].stim,
                     corner_dates[i].typed ? corner_dates[i].want
                                           : date_math(corner_dates[i].stim));
    end

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      in_t it;
      it = random_date_pair();
      send_date_pair(it, date_math(it));
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result channel
  // --------------------------------------------------------------------------
  initial begin
    bit          held;
    int unsigned gap;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = next_gap(out_quiet);
      if (!held && results_seen >= HOLD_AFTER) begin
        // Long hold-off so the pipeline fills and the input stalls.
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item arrived with no item outstanding");
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("next_day", oldest.next_day, out_ch.next_day);
        check_field("next_month", oldest.next_month, out_ch.next_month);
        check_field("next_year", oldest.next_year, out_ch.next_year);
        check_field("prev_day", oldest.prev_day, out_ch.prev_day);
        check_field("prev_month", oldest.prev_month, out_ch.prev_month);
        check_field("prev_year", oldest.prev_year, out_ch.prev_year);
        check_field("week_of_year", oldest.week_of_year, out_ch.week_of_year);
        check_field("day_serial", oldest.day_serial, out_ch.day_serial);
        check_field("distance_days", oldest.distance_days, out_ch.distance_days);
        check_field("days_to_anniversary", oldest.days_to_anniversary,
                    out_ch.days_to_anniversary);
      end
    end
  end

  // Ends the run when neither channel moves an item for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $error("no item moved for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule : gregorian_date_arithmetic_core_tb
